// File: src/dpy_pkg.sv
package dpy_pkg;

  // Number of fraction bits in every Q-format value.
  localparam int FRAC_BITS = 16;

  // Widths of the datapath.
  localparam int DW = 32;   // one tensor component or register
  localparam int WW = 72;   // nine times the deviator's sum of squares
  localparam int RW = 34;   // unsaturated square root
  localparam int PW = 64;   // slope times mean

  // Division by three of a 34-bit magnitude: x = h * 2^18 + l gives
  // x / 3 = h * (2^18 - 1) / 3 + (h + l) / 3, the last part through a reciprocal.
  localparam logic [16:0] THIRD_HI = 17'd87381;
  localparam logic [19:0] THIRD_LO = 20'd699051;
  localparam int THIRD_SHIFT = 21;

  typedef logic signed [DW-1:0] comp_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_DP_SLOPE  = 1'b0,
    REG_DP_OFFSET = 1'b1
  } cfg_reg_t;

  // Values that ride along the square root stages.
  typedef struct packed {
    logic signed [DW-1:0] mean;
    logic signed [PW-1:0] prod;
  } side_t;

  // One square root stage's working set.
  typedef struct packed {
    logic [WW-1:0] rem;
    logic [RW-1:0] root;
    side_t         side;
  } sq_t;

endpackage

// File: src/drucker_prager_yield_3x3.sv
// Channel   Signals                                   Direction
// input     in_valid, in_stall, sig_xx .. sig_zz      tensor in, stall out
// output    out_valid, out_stall, mean_stress,        result out, stall in
//           von_mises, yield_value
// config    cfg_wen, cfg_index, cfg_data              write only
//
// One request is taken every cycle while the output is not stalled.
// The pipeline is made of five front stages, one stage per root bit (34) and
// the output register.
// Reset clears the valid bits and both configuration registers to zero.
// A stall on a valid output freezes the whole pipeline and stalls the input.
module drucker_prager_yield_3x3 (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  sig_xx,
  input  logic signed [31:0]  sig_xy,
  input  logic signed [31:0]  sig_xz,
  input  logic signed [31:0]  sig_yx,
  input  logic signed [31:0]  sig_yy,
  input  logic signed [31:0]  sig_yz,
  input  logic signed [31:0]  sig_zx,
  input  logic signed [31:0]  sig_zy,
  input  logic signed [31:0]  sig_zz,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  mean_stress,
  output logic [30:0]         von_mises,
  output logic signed [31:0]  yield_value,
  input  logic                cfg_wen,
  input  dpy_pkg::cfg_reg_t   cfg_index,
  input  logic [31:0]         cfg_data
);
  import dpy_pkg::*;

  logic signed [31:0] dp_slope;
  logic signed [31:0] dp_offset;
  logic               adv;
  comp_t              sig [9];
  logic               v_chain [RW+1];
  sq_t                sq_chain [RW+1];

  logic signed [PW-1:0] prod_rnd;
  logic signed [65:0]   pq;
  logic signed [65:0]   yv;
  logic [30:0]          vm_c;
  logic signed [31:0]   y_c;

  // The pipeline moves unless a finished result is held back.
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  assign sig[0] = sig_xx;
  assign sig[1] = sig_xy;
  assign sig[2] = sig_xz;
  assign sig[3] = sig_yx;
  assign sig[4] = sig_yy;
  assign sig[5] = sig_yz;
  assign sig[6] = sig_zx;
  assign sig[7] = sig_zy;
  assign sig[8] = sig_zz;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dp_slope <= '0;
      dp_offset <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_DP_SLOPE:  dp_slope <= cfg_data;
        REG_DP_OFFSET: dp_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  dpy_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .sig      (sig),
    .slope    (dp_slope),
    .v_out    (v_chain[0]),
    .sq_out   (sq_chain[0])
  );

  // One root bit per stage, most significant first.
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    dpy_sqrt_step u_step (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .bit_pos (6'(RW - 1 - k)),
      .v_in    (v_chain[k]),
      .sq_in   (sq_chain[k]),
      .v_out   (v_chain[k+1]),
      .sq_out  (sq_chain[k+1])
    );
  end

  // Round the slope product, form the yield value and saturate.
  always_comb begin
    prod_rnd = sq_chain[RW].side.prod + (PW'(1) <<< (FRAC_BITS - 1));
    pq = 66'(prod_rnd >>> FRAC_BITS);
    yv = $signed(66'(sq_chain[RW].root)) - pq - 66'(dp_offset);
    if (yv > 66'sd2147483647) begin
      y_c = 32'sh7FFFFFFF;
    end else if (yv < -66'sd2147483648) begin
      y_c = 32'sh80000000;
    end else begin
      y_c = 32'(yv);
    end
    vm_c = (sq_chain[RW].root > RW'(31'h7FFFFFFF)) ? 31'h7FFFFFFF
                                                  : sq_chain[RW].root[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v_chain[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mean_stress <= sq_chain[RW].side.mean;
      von_mises <= vm_c;
      yield_value <= y_c;
    end
  end

endmodule

// File: src/dpy_front.sv
module dpy_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  dpy_pkg::comp_t        sig [9],
  input  logic signed [31:0]    slope,
  output logic                  v_out,
  output dpy_pkg::sq_t          sq_out
);
  import dpy_pkg::*;

  // Stage 1: trace, diagonal terms and off-diagonal magnitudes.
  logic               v1;
  logic signed [33:0] tr1;
  comp_t              diag1 [3];
  logic [31:0]        off1 [6];

  // Stage 2: deviator magnitudes and the mean's dividend.
  logic               v2;
  logic [33:0]        dmag2 [3];
  logic [31:0]        off2 [6];
  logic [33:0]        x2;
  logic               neg2;

  // Stage 3: partial products.
  logic               v3;
  logic [33:0]        hh3 [3];
  logic [33:0]        hl3 [3];
  logic [33:0]        ll3 [3];
  logic [63:0]        osq3 [6];
  logic [32:0]        mh3;
  logic [38:0]        ml3;
  logic               neg3;

  // Stage 4: sums and the mean.
  logic               v4;
  logic [69:0]        dsum4;
  logic [66:0]        osum4;
  logic signed [31:0] mean4;

  // Combinational values between stages.
  logic signed [33:0] tr_c;
  logic [31:0]        off_c [6];
  logic [33:0]        dmag_c [3];
  logic [33:0]        trmag_c;
  logic [67:0]        dsq_c [3];
  logic [18:0]        hl_sum_c;
  logic [32:0]        q_c;

  always_comb begin
    logic signed [32:0] e;
    logic signed [35:0] d;
    tr_c = 34'(sig[0]) + 34'(sig[4]) + 34'(sig[8]);
    for (int k = 0; k < 6; k++) begin
      e = 33'(sig[(k < 3) ? ((k == 0) ? 1 : (k == 1) ? 2 : 3)
                          : ((k == 3) ? 5 : (k == 4) ? 6 : 7)]);
      off_c[k] = (e < 0) ? 32'(-e) : 32'(e);
    end
    for (int k = 0; k < 3; k++) begin
      d = (36'(diag1[k]) <<< 1) + 36'(diag1[k]) - 36'(tr1);
      dmag_c[k] = (d < 0) ? 34'(-d) : 34'(d);
    end
    trmag_c = (tr1 < 0) ? 34'(-tr1) : 34'(tr1);
    for (int k = 0; k < 3; k++) begin
      dsq_c[k] = (68'(hh3[k]) << 34) + (68'(hl3[k]) << 18) + 68'(ll3[k]);
    end
    hl_sum_c = 19'(x2[33:18]) + 19'(x2[17:0]);
    q_c = mh3 + 33'(ml3[38:THIRD_SHIFT]);
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v_out <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v_out <= v4;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      tr1 <= tr_c;
      diag1[0] <= sig[0];
      diag1[1] <= sig[4];
      diag1[2] <= sig[8];
      off1 <= off_c;

      dmag2 <= dmag_c;
      off2 <= off1;
      x2 <= trmag_c + 34'd1;
      neg2 <= tr1[33];

      for (int k = 0; k < 3; k++) begin
        hh3[k] <= 34'(dmag2[k][33:17]) * 34'(dmag2[k][33:17]);
        hl3[k] <= 34'(dmag2[k][33:17]) * 34'(dmag2[k][16:0]);
        ll3[k] <= 34'(dmag2[k][16:0]) * 34'(dmag2[k][16:0]);
      end
      for (int k = 0; k < 6; k++) begin
        osq3[k] <= 64'(off2[k]) * 64'(off2[k]);
      end
      mh3 <= 33'(x2[33:18]) * 33'(THIRD_HI);
      ml3 <= 39'(hl_sum_c) * 39'(THIRD_LO);
      neg3 <= neg2;

      dsum4 <= 70'(dsq_c[0]) + 70'(dsq_c[1]) + 70'(dsq_c[2]);
      osum4 <= 67'(osq3[0]) + 67'(osq3[1]) + 67'(osq3[2])
             + 67'(osq3[3]) + 67'(osq3[4]) + 67'(osq3[5]);
      mean4 <= neg3 ? -$signed(32'(q_c)) : $signed(32'(q_c));

      sq_out.rem <= 72'(dsum4) + (72'(osum4) << 3) + 72'(osum4);
      sq_out.root <= '0;
      sq_out.side.mean <= mean4;
      sq_out.side.prod <= 64'(slope) * 64'(mean4);
    end
  end

endmodule

// File: src/dpy_sqrt_step.sv
module dpy_sqrt_step (
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  logic [5:0]   bit_pos,
  input  logic         v_in,
  input  dpy_pkg::sq_t sq_in,
  output logic         v_out,
  output dpy_pkg::sq_t sq_out
);
  import dpy_pkg::*;

  logic [RW:0]   trial;
  logic [WW-1:0] tval;
  logic [WW-1:0] tval6;
  logic          take;

  // Setting this bit costs 6 * 2^b * (2r + 2^b) of the remainder.
  always_comb begin
    trial = {sq_in.root, 1'b0} | ((RW + 1)'(1) << bit_pos);
    tval = WW'(trial) << bit_pos;
    tval6 = (tval << 1) + (tval << 2);
    take = (sq_in.rem >= tval6);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (adv) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_out.rem <= take ? (sq_in.rem - tval6) : sq_in.rem;
      sq_out.root <= take ? (sq_in.root | (RW'(1) << bit_pos)) : sq_in.root;
      sq_out.side <= sq_in.side;
    end
  end

endmodule
